// ===== src/trb_pkg.sv =====
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, register codes and the channel blend function for the
// triangle edge rasterizer with alpha blend.
// ----------------------------------------------------------------------------
package trb_pkg;

  localparam int COORD_W     = 14;
  localparam int DELTA_W     = COORD_W + 1;
  localparam int PROD_W      = 2 * DELTA_W;
  localparam int EDGE_W      = 32;
  localparam int ROW_WIDTH_W = 13;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_EDGES   = 3;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd256;
  localparam logic [7:0]             ALPHA_OPAQUE  = 8'hff;
  localparam logic [8:0]             ALPHA_FULL    = 9'd256;

  typedef enum logic [2:0] {
    REG_V0_X      = 3'd0,
    REG_V0_Y      = 3'd1,
    REG_V1_X      = 3'd2,
    REG_V1_Y      = 3'd3,
    REG_V2_X      = 3'd4,
    REG_V2_Y      = 3'd5,
    REG_FILL      = 3'd6,
    REG_ROW_WIDTH = 3'd7
  } reg_idx_t;

  typedef logic [EDGE_W-1:0] edge_t;

  typedef struct packed {
    logic [NUM_EDGES-1:0][COORD_W-1:0] vx;
    logic [NUM_EDGES-1:0][COORD_W-1:0] vy;
    logic [31:0]                       fill_color;
    logic [ROW_WIDTH_W-1:0]            row_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] dst_blue;
    logic [7:0] dst_green;
    logic [7:0] dst_red;
    logic [7:0] dst_alpha;
    logic       frame_last;
  } pix_t;

  typedef struct packed {
    pix_t                        pix;
    logic [NUM_EDGES-1:0][EDGE_W-1:0] edge_init;
  } setup_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       covered;
    logic       frame_done;
  } res_t;

  // Signed difference of two vertex coordinates, one bit wider.
  function automatic logic [DELTA_W-1:0] coord_diff(input logic [COORD_W-1:0] q,
                                                    input logic [COORD_W-1:0] p);
    coord_diff = {q[COORD_W-1], q} - {p[COORD_W-1], p};
  endfunction

  // (c*a + d*(256-a)) >> 8, a in 0..256
  function automatic logic [7:0] blend_chan(input logic [7:0] c,
                                            input logic [7:0] d,
                                            input logic [8:0] a);
    logic [8:0]  inv;
    logic [16:0] pc;
    logic [16:0] pd;
    logic [16:0] sum;
    inv = ALPHA_FULL - a;
    pc  = {9'd0, c} * {8'd0, a};
    pd  = {9'd0, d} * {8'd0, inv};
    sum = pc + pd;
    blend_chan = sum[15:8];
  endfunction

endpackage

// ===== src/trb_if.sv =====
// ----------------------------------------------------------------------------
// trb_if
// Valid/ready pixel channels: destination pixels in, blended pixels out.
// ----------------------------------------------------------------------------
interface trb_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dst_blue;
  logic [7:0] dst_green;
  logic [7:0] dst_red;
  logic [7:0] dst_alpha;
  logic       frame_last;

  modport source (output valid, dst_blue, dst_green, dst_red, dst_alpha, frame_last,
                  input ready);
  modport sink (input valid, dst_blue, dst_green, dst_red, dst_alpha, frame_last,
                output ready);
endinterface

interface trb_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;
  logic       covered;
  logic       frame_done;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, covered,
                  frame_done, input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_alpha, covered,
                frame_done, output ready);
endinterface

// ===== src/trb_cfg.sv =====
// ----------------------------------------------------------------------------
// trb_cfg
// APB register file: triangle vertices, fill color and row width.
// ----------------------------------------------------------------------------
module trb_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [trb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [trb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output trb_pkg::cfg_t                  cfg
);

  trb_pkg::cfg_t     cfg_r;
  trb_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = trb_pkg::reg_idx_t'(paddr[trb_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vx         <= '0;
      cfg_r.vy         <= '0;
      cfg_r.fill_color <= '0;
      cfg_r.row_width  <= trb_pkg::ROW_WIDTH_RST;
    end else if (wr_en) begin
      case (idx)
        trb_pkg::REG_V0_X:      cfg_r.vx[0]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_V0_Y:      cfg_r.vy[0]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_V1_X:      cfg_r.vx[1]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_V1_Y:      cfg_r.vy[1]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_V2_X:      cfg_r.vx[2]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_V2_Y:      cfg_r.vy[2]      <= pwdata[trb_pkg::COORD_W-1:0];
        trb_pkg::REG_FILL:      cfg_r.fill_color <= pwdata;
        trb_pkg::REG_ROW_WIDTH: cfg_r.row_width  <= pwdata[trb_pkg::ROW_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      trb_pkg::REG_V0_X:      prdata = 32'(cfg_r.vx[0]);
      trb_pkg::REG_V0_Y:      prdata = 32'(cfg_r.vy[0]);
      trb_pkg::REG_V1_X:      prdata = 32'(cfg_r.vx[1]);
      trb_pkg::REG_V1_Y:      prdata = 32'(cfg_r.vy[1]);
      trb_pkg::REG_V2_X:      prdata = 32'(cfg_r.vx[2]);
      trb_pkg::REG_V2_Y:      prdata = 32'(cfg_r.vy[2]);
      trb_pkg::REG_FILL:      prdata = cfg_r.fill_color;
      trb_pkg::REG_ROW_WIDTH: prdata = 32'(cfg_r.row_width);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== src/trb_setup.sv =====
// ----------------------------------------------------------------------------
// trb_setup
// Input stage: capture the pixel and the frame-start edge values
// E = (-Px)*(Qy-Py) - (-Py)*(Qx-Px) for each triangle edge.
// ----------------------------------------------------------------------------
module trb_setup (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  trb_pkg::pix_t   in_pix,
  input  trb_pkg::cfg_t   cfg,
  output logic            st_valid,
  input  logic            st_ready,
  output trb_pkg::setup_t st_data
);

  logic                                              st_valid_r;
  trb_pkg::setup_t                                   st_data_r;
  logic [trb_pkg::NUM_EDGES-1:0][trb_pkg::EDGE_W-1:0] init_nxt;
  logic                                              load;

  for (genvar i = 0; i < trb_pkg::NUM_EDGES; i++) begin : g_edge
    localparam int Q = (i == trb_pkg::NUM_EDGES - 1) ? 0 : i + 1;
    logic signed [trb_pkg::DELTA_W-1:0] dx, dy, npx, npy;
    logic signed [trb_pkg::PROD_W-1:0]  p1, p2;
    logic        [trb_pkg::PROD_W:0]    diff;

    assign dx   = trb_pkg::coord_diff(cfg.vx[Q], cfg.vx[i]);
    assign dy   = trb_pkg::coord_diff(cfg.vy[Q], cfg.vy[i]);
    assign npx  = -{cfg.vx[i][trb_pkg::COORD_W-1], cfg.vx[i]};
    assign npy  = -{cfg.vy[i][trb_pkg::COORD_W-1], cfg.vy[i]};
    assign p1   = npx * dy;
    assign p2   = npy * dx;
    assign diff = {p1[trb_pkg::PROD_W-1], p1} - {p2[trb_pkg::PROD_W-1], p2};
    assign init_nxt[i] = {{(trb_pkg::EDGE_W - trb_pkg::PROD_W - 1){diff[trb_pkg::PROD_W]}},
                          diff};
  end

  assign in_ready = ~st_valid_r | st_ready;
  assign load     = in_valid & in_ready;
  assign st_valid = st_valid_r;
  assign st_data  = st_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      st_data_r.pix       <= in_pix;
      st_data_r.edge_init <= init_nxt;
    end
  end

endmodule

// ===== src/trb_raster.sv =====
// ----------------------------------------------------------------------------
// trb_raster
// Edge walk, coverage test, color blend and result register.
// ----------------------------------------------------------------------------
module trb_raster #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            st_valid,
  output logic            st_ready,
  input  trb_pkg::setup_t st_data,
  input  trb_pkg::cfg_t   cfg,
  output logic            res_valid,
  input  logic            res_ready,
  output trb_pkg::res_t   res
);

  localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);
  localparam int CMP_W = ((CNT_W > trb_pkg::ROW_WIDTH_W) ? CNT_W : trb_pkg::ROW_WIDTH_W) + 1;
  localparam int NE    = trb_pkg::NUM_EDGES;
  localparam int EW    = trb_pkg::EDGE_W;
  localparam int DW    = trb_pkg::DELTA_W;

  logic [NE-1:0][EW-1:0] edge_cur_r, edge_cur_nxt;
  logic [NE-1:0][EW-1:0] edge_row_r, edge_row_nxt;
  logic [NE-1:0][EW-1:0] cur_sel, row_sel, dx_ext, dy_ext;
  logic [CNT_W-1:0]      col_r, col_nxt, col_sel;
  logic                  frame_begin_r, frame_begin_nxt;
  logic                  res_valid_r;
  trb_pkg::res_t         res_r, res_nxt;
  logic                  load;
  logic [CMP_W-1:0]      rw_ext, max_ext, width_eff, col_inc;
  logic                  row_end;
  logic                  cov;
  logic [8:0]            alpha;
  trb_pkg::pix_t         pix;

  for (genvar i = 0; i < NE; i++) begin : g_delta
    localparam int Q = (i == NE - 1) ? 0 : i + 1;
    logic [DW-1:0] dx, dy;
    assign dx        = trb_pkg::coord_diff(cfg.vx[Q], cfg.vx[i]);
    assign dy        = trb_pkg::coord_diff(cfg.vy[Q], cfg.vy[i]);
    assign dx_ext[i] = {{(EW - DW){dx[DW-1]}}, dx};
    assign dy_ext[i] = {{(EW - DW){dy[DW-1]}}, dy};
  end

  assign st_ready  = ~res_valid_r | res_ready;
  assign load      = st_valid & st_ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign pix       = st_data.pix;

  // Clamp row width to 1..MAX_ROW_WIDTH.
  assign rw_ext    = CMP_W'(cfg.row_width);
  assign max_ext   = CMP_W'(MAX_ROW_WIDTH);
  assign width_eff = (rw_ext == '0) ? CMP_W'(1) : ((rw_ext > max_ext) ? max_ext : rw_ext);

  always_comb begin
    cur_sel = frame_begin_r ? st_data.edge_init : edge_cur_r;
    row_sel = frame_begin_r ? st_data.edge_init : edge_row_r;
    col_sel = frame_begin_r ? '0 : col_r;
    col_inc = CMP_W'(col_sel) + CMP_W'(1);
    row_end = (col_inc >= width_eff);

    cov = ~((cur_sel[0][EW-1] ^ cur_sel[1][EW-1]) | (cur_sel[0][EW-1] ^ cur_sel[2][EW-1]));

    alpha = (cfg.fill_color[31:24] == trb_pkg::ALPHA_OPAQUE) ?
            trb_pkg::ALPHA_FULL : {1'b0, cfg.fill_color[31:24]};

    res_nxt.out_blue   = cov ? trb_pkg::blend_chan(cfg.fill_color[7:0], pix.dst_blue, alpha)
                             : pix.dst_blue;
    res_nxt.out_green  = cov ? trb_pkg::blend_chan(cfg.fill_color[15:8], pix.dst_green, alpha)
                             : pix.dst_green;
    res_nxt.out_red    = cov ? trb_pkg::blend_chan(cfg.fill_color[23:16], pix.dst_red, alpha)
                             : pix.dst_red;
    res_nxt.out_alpha  = pix.dst_alpha;
    res_nxt.covered    = cov;
    res_nxt.frame_done = pix.frame_last;

    edge_cur_nxt    = cur_sel;
    edge_row_nxt    = row_sel;
    col_nxt         = '0;
    frame_begin_nxt = 1'b0;
    if (pix.frame_last) begin
      frame_begin_nxt = 1'b1;
    end else if (row_end) begin
      for (int i = 0; i < NE; i++) begin
        edge_row_nxt[i] = row_sel[i] - dx_ext[i];
        edge_cur_nxt[i] = row_sel[i] - dx_ext[i];
      end
    end else begin
      col_nxt = CNT_W'(col_inc);
      for (int i = 0; i < NE; i++) begin
        edge_cur_nxt[i] = cur_sel[i] + dy_ext[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r   <= 1'b0;
      frame_begin_r <= 1'b1;
      col_r         <= '0;
      edge_cur_r    <= '0;
      edge_row_r    <= '0;
    end else begin
      if (st_ready) begin
        res_valid_r <= st_valid;
      end
      if (load) begin
        frame_begin_r <= frame_begin_nxt;
        col_r         <= col_nxt;
        edge_cur_r    <= edge_cur_nxt;
        edge_row_r    <= edge_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/triangle_edge_raster_blend.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_raster_blend
// Streams destination pixels in raster order, tests each against a triangle
// with three incremental edge functions and alpha-blends the fill color into
// covered pixels.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Transaction
//  -------  ---------  ----------------------  --------------------------------
//  in_ch    sink       valid/ready             one destination pixel + frame_last
//  out_ch   source     valid/ready             one result pixel + covered/done
//  APB      slave      psel/penable, pready=1  one 32-bit register write/read
//
//  One pixel per clock sustained while out_ch is ready; an accepted pixel passes
//  through the setup register, then the result register, before its result
//  is valid on out_ch.
//  The setup stage holds the two 15x15 products per edge; the result stage
//  holds the edge walk, the sign test and the six 8x9 blend products.
//  Reset (rst_n low, synchronous) empties both stages, restores the register
//  defaults and arms the frame start so the next pixel lands at (0,0).
//  A stall on out_ch holds the result register; the setup stage still takes
//  one more transaction, if it is empty, before in_ch ready drops.
//
module triangle_edge_raster_blend #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  trb_pix_in_if.sink                     in_ch,
  trb_pix_out_if.source                  out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [trb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [trb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  trb_pkg::cfg_t   cfg;
  trb_pkg::pix_t   in_pix;
  trb_pkg::setup_t st_data;
  trb_pkg::res_t   res;
  logic            st_valid;
  logic            st_ready;

  // Gather the input payload into one struct.
  assign in_pix.dst_blue   = in_ch.dst_blue;
  assign in_pix.dst_green  = in_ch.dst_green;
  assign in_pix.dst_red    = in_ch.dst_red;
  assign in_pix.dst_alpha  = in_ch.dst_alpha;
  assign in_pix.frame_last = in_ch.frame_last;

  trb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: capture pixel, form frame-start edge values from the vertices.
  trb_setup u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_pix   (in_pix),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_data  (st_data)
  );

  // Stage 2: advance the edge walk in pixel order, test coverage, blend.
  trb_raster #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st_data   (st_data),
    .cfg       (cfg),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  // Drive the result payload from the result register.
  assign out_ch.out_blue   = res.out_blue;
  assign out_ch.out_green  = res.out_green;
  assign out_ch.out_red    = res.out_red;
  assign out_ch.out_alpha  = res.out_alpha;
  assign out_ch.covered    = res.covered;
  assign out_ch.frame_done = res.frame_done;

endmodule
